[sv/ppp_pkg.sv]
package ppp_pkg;

    localparam int CoordFrac   = 16;
    localparam int TrigFrac    = 16;
    localparam int TrigW       = TrigFrac + 2;
    localparam int CfgW        = 32;
    localparam int CoordW      = 32;
    localparam int AngW        = 26;
    localparam int FovW        = 24;
    localparam int SizeW       = 16;
    localparam int DepthW      = 31;
    localparam int FocalW      = 32;

    localparam int AngFull     = 23592960;
    localparam int AngHalf     = 11796480;
    localparam int AngQuart    = 5898240;
    localparam int CordicSteps = 18;
    localparam int CordicGain  = 652032874;
    localparam int CordW       = 34;
    localparam int FocalShift  = 16;
    localparam int DivNumW     = CordW + FocalShift;

    localparam int DiffW       = CoordW + 1;
    localparam int ProdW       = DiffW + TrigW;
    localparam int RotW        = ProdW + 2 - TrigFrac;
    localparam int DenW        = RotW - 1;
    localparam int RatioShift  = 20;
    localparam int NumW        = RotW + RatioShift;
    localparam int DepthMin    = (2 ** CoordFrac + 999) / 1000;

    localparam logic [FovW-1:0]  FovReset    = 24'd5898240;
    localparam logic [SizeW-1:0] WidthReset  = 16'd1920;
    localparam logic [SizeW-1:0] HeightReset = 16'd1080;

    typedef enum logic [2:0] {
        RegCamX   = 3'd0,
        RegCamY   = 3'd1,
        RegCamZ   = 3'd2,
        RegPitch  = 3'd3,
        RegYaw    = 3'd4,
        RegFov    = 3'd5,
        RegWidth  = 3'd6,
        RegHeight = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CoordW-1:0] world_x;
        logic signed [CoordW-1:0] world_y;
        logic signed [CoordW-1:0] world_z;
    } point_t;

    typedef struct packed {
        logic                     on_screen;
        logic signed [CoordW-1:0] screen_x;
        logic signed [CoordW-1:0] screen_y;
        logic [DepthW-1:0]        view_depth;
    } result_t;

    typedef struct packed {
        logic signed [CoordW-1:0] cam_x;
        logic signed [CoordW-1:0] cam_y;
        logic signed [CoordW-1:0] cam_z;
        logic [SizeW-1:0]         width;
        logic [SizeW-1:0]         height;
        logic signed [TrigW-1:0]  psin;
        logic signed [TrigW-1:0]  pcos;
        logic signed [TrigW-1:0]  ysin;
        logic signed [TrigW-1:0]  ycos;
        logic signed [TrigW-1:0]  spsy;
        logic signed [TrigW-1:0]  spcy;
        logic signed [TrigW-1:0]  cpsy;
        logic signed [TrigW-1:0]  cpcy;
        logic [FocalW-1:0]        focal_mag;
        logic                     focal_neg;
        logic                     usable;
    } setup_t;

    typedef struct packed {
        logic              ok;
        logic              neg_x;
        logic              neg_y;
        logic [RotW-1:0]   mag_x;
        logic [RotW-1:0]   mag_y;
        logic [DenW-1:0]   den;
        logic [DepthW-1:0] depth;
    } xf_t;

    typedef struct packed {
        logic              ok;
        logic              neg_x;
        logic              neg_y;
        logic [DepthW-1:0] depth;
    } div_tag_t;

    function automatic logic [22:0] atan_deg(input logic [4:0] i);
        logic [22:0] r;
        unique case (i)
            5'd0:    r = 23'd2949120;
            5'd1:    r = 23'd1740967;
            5'd2:    r = 23'd919879;
            5'd3:    r = 23'd466945;
            5'd4:    r = 23'd234379;
            5'd5:    r = 23'd117265;
            5'd6:    r = 23'd58666;
            5'd7:    r = 23'd29335;
            5'd8:    r = 23'd14668;
            5'd9:    r = 23'd7334;
            5'd10:   r = 23'd3667;
            5'd11:   r = 23'd1833;
            5'd12:   r = 23'd917;
            5'd13:   r = 23'd458;
            5'd14:   r = 23'd229;
            5'd15:   r = 23'd115;
            5'd16:   r = 23'd57;
            5'd17:   r = 23'd29;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[sv/ppp_setup.sv]
module ppp_setup
    import ppp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  reg_idx_t        cfg_index,
    input  logic [CfgW-1:0] cfg_data,
    output logic            busy,
    output setup_t          setup
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_ITER  = 7'b0000100,
        S_STORE = 7'b0001000,
        S_PROD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        AngPitch = 2'd0,
        AngYaw   = 2'd1,
        AngFov   = 2'd2
    } ang_sel_t;

    localparam logic signed [AngW:0]  AngFullS  = (AngW + 1)'(AngFull);
    localparam logic signed [AngW:0]  AngHalfS  = (AngW + 1)'(AngHalf);
    localparam logic signed [AngW:0]  AngQuartS = (AngW + 1)'(AngQuart);
    localparam logic signed [CordW:0] TrigRound = (CordW + 1)'(2 ** (29 - TrigFrac));
    localparam logic signed [CordW:0] TrigOne   = (CordW + 1)'(2 ** TrigFrac);
    localparam logic [4:0]            LastIter  = 5'(CordicSteps - 1);
    localparam logic [5:0]            LastDiv   = 6'(DivNumW - 1);
    localparam logic [19:0]           UsableScale = 20'd1000000;
    localparam logic [FocalW-1:0]     FocalMax    = 32'h7FFF_FFFF;
    localparam logic [FocalW-1:0]     FocalMinMag = 32'h8000_0000;

    function automatic logic signed [TrigW-1:0] to_trig(input logic signed [CordW-1:0] v);
        logic signed [CordW:0] s;
        logic signed [CordW:0] r;
        s = (CordW + 1)'(v) + TrigRound;
        r = s >>> (30 - TrigFrac);
        if (r > TrigOne) r = TrigOne;
        if (r < -TrigOne) r = -TrigOne;
        return TrigW'(r);
    endfunction

    state_t   state_reg;
    ang_sel_t ang_sel_reg;
    logic [4:0] iter_reg;
    logic [5:0] dcnt_reg;

    logic signed [CoordW-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [AngW-1:0]   pitch_reg, yaw_reg;
    logic [FovW-1:0]          fov_reg;
    logic [SizeW-1:0]         width_reg, height_reg;

    logic signed [CordW-1:0] x_reg, y_reg, fs_reg, fc_reg;
    logic signed [AngW-1:0]  z_reg;
    logic                    flip_reg;
    logic signed [TrigW-1:0] psin_reg, pcos_reg, ysin_reg, ycos_reg;
    logic signed [TrigW-1:0] spsy_reg, spcy_reg, cpsy_reg, cpcy_reg;
    logic [FocalW-1:0]       focal_mag_reg;
    logic                    focal_neg_reg, usable_reg;
    logic [CordW-1:0]        rem_reg, den_reg;
    logic [DivNumW-1:0]      nq_reg;
    logic                    dneg_reg;

    logic signed [AngW:0]    a0, a1, a2, a3, a4;
    logic                    flip_init;
    logic signed [CordW-1:0] xs, ys, s_val, c_val;
    logic signed [AngW-1:0]  at;
    logic [CordW-1:0]        fs_mag, fc_mag;
    logic signed [2*TrigW-1:0] pp_ss, pp_sc, pp_cs, pp_cc;
    logic [CordW:0]          trial;
    logic                    ge, q_big;

    always_comb
    begin
        unique case (ang_sel_reg)
            AngPitch: a0 = (AngW + 1)'(pitch_reg);
            AngYaw:   a0 = (AngW + 1)'(yaw_reg);
            AngFov:   a0 = (AngW + 1)'({1'b0, fov_reg[FovW-1:1]});
            default:  a0 = '0;
        endcase
        a1 = (a0 < 0) ? a0 + AngFullS : a0;
        if (a1 < 0)
            a2 = a1 + AngFullS;
        else if (a1 >= AngFullS)
            a2 = a1 - AngFullS;
        else
            a2 = a1;
        a3 = (a2 >= AngHalfS) ? a2 - AngFullS : a2;
        flip_init = 1'b1;
        if (a3 > AngQuartS)
            a4 = a3 - AngHalfS;
        else if (a3 < -AngQuartS)
            a4 = a3 + AngHalfS;
        else
        begin
            a4 = a3;
            flip_init = 1'b0;
        end
    end

    assign xs    = x_reg >>> iter_reg;
    assign ys    = y_reg >>> iter_reg;
    assign at    = AngW'(atan_deg(iter_reg));
    assign s_val = flip_reg ? -y_reg : y_reg;
    assign c_val = flip_reg ? -x_reg : x_reg;

    assign fs_mag = fs_reg[CordW-1] ? CordW'(-fs_reg) : CordW'(fs_reg);
    assign fc_mag = fc_reg[CordW-1] ? CordW'(-fc_reg) : CordW'(fc_reg);
    assign pp_ss  = psin_reg * ysin_reg;
    assign pp_sc  = psin_reg * ycos_reg;
    assign pp_cs  = pcos_reg * ysin_reg;
    assign pp_cc  = pcos_reg * ycos_reg;

    assign trial = {rem_reg, nq_reg[DivNumW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign q_big = |nq_reg[DivNumW-1:FocalW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            ang_sel_reg <= AngPitch;
            iter_reg    <= '0;
            dcnt_reg    <= '0;
            cam_x_reg   <= '0;
            cam_y_reg   <= '0;
            cam_z_reg   <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            fov_reg     <= FovReset;
            width_reg   <= WidthReset;
            height_reg  <= HeightReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                RegCamX:   cam_x_reg  <= cfg_data;
                RegCamY:   cam_y_reg  <= cfg_data;
                RegCamZ:   cam_z_reg  <= cfg_data;
                RegPitch:  pitch_reg  <= cfg_data[AngW-1:0];
                RegYaw:    yaw_reg    <= cfg_data[AngW-1:0];
                RegFov:    fov_reg    <= cfg_data[FovW-1:0];
                RegWidth:  width_reg  <= cfg_data[SizeW-1:0];
                RegHeight: height_reg <= cfg_data[SizeW-1:0];
            endcase
            state_reg   <= S_LOAD;
            ang_sel_reg <= AngPitch;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: ;
                S_LOAD:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    iter_reg <= iter_reg + 5'd1;
                    if (iter_reg == LastIter)
                        state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    if (ang_sel_reg == AngFov)
                        state_reg <= S_PROD;
                    else
                    begin
                        ang_sel_reg <= (ang_sel_reg == AngPitch) ? AngYaw : AngFov;
                        state_reg   <= S_LOAD;
                    end
                end
                S_PROD:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= (fs_reg == '0) ? S_IDLE : S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == LastDiv)
                        state_reg <= S_DONE;
                end
                S_DONE:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_LOAD:
            begin
                x_reg    <= CordW'(CordicGain);
                y_reg    <= '0;
                z_reg    <= AngW'(a4);
                flip_reg <= flip_init;
            end
            S_ITER:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            S_STORE:
            begin
                unique case (ang_sel_reg)
                    AngPitch:
                    begin
                        psin_reg <= to_trig(s_val);
                        pcos_reg <= to_trig(c_val);
                    end
                    AngYaw:
                    begin
                        ysin_reg <= to_trig(s_val);
                        ycos_reg <= to_trig(c_val);
                    end
                    AngFov:
                    begin
                        fs_reg <= s_val;
                        fc_reg <= c_val;
                    end
                    default: ;
                endcase
            end
            S_PROD:
            begin
                spsy_reg      <= pp_ss[TrigFrac+TrigW-1:TrigFrac];
                spcy_reg      <= pp_sc[TrigFrac+TrigW-1:TrigFrac];
                cpsy_reg      <= pp_cs[TrigFrac+TrigW-1:TrigFrac];
                cpcy_reg      <= pp_cc[TrigFrac+TrigW-1:TrigFrac];
                usable_reg    <= (width_reg != '0) && (height_reg != '0) && (fs_reg != '0)
                                 && ((fs_mag * UsableScale) >= (CordW + 20)'(fc_mag));
                focal_mag_reg <= '0;
                focal_neg_reg <= 1'b0;
                rem_reg       <= '0;
                den_reg       <= fs_mag;
                nq_reg        <= {fc_mag, FocalShift'(0)};
                dneg_reg      <= fc_reg[CordW-1] ^ fs_reg[CordW-1];
            end
            S_DIV:
            begin
                rem_reg <= ge ? CordW'(trial - {1'b0, den_reg}) : trial[CordW-1:0];
                nq_reg  <= {nq_reg[DivNumW-2:0], ge};
            end
            S_DONE:
            begin
                if (q_big)
                    focal_mag_reg <= dneg_reg ? FocalMinMag : FocalMax;
                else
                    focal_mag_reg <= nq_reg[FocalW-1:0];
                focal_neg_reg <= dneg_reg;
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    assign setup.cam_x     = cam_x_reg;
    assign setup.cam_y     = cam_y_reg;
    assign setup.cam_z     = cam_z_reg;
    assign setup.width     = width_reg;
    assign setup.height    = height_reg;
    assign setup.psin      = psin_reg;
    assign setup.pcos      = pcos_reg;
    assign setup.ysin      = ysin_reg;
    assign setup.ycos      = ycos_reg;
    assign setup.spsy      = spsy_reg;
    assign setup.spcy      = spcy_reg;
    assign setup.cpsy      = cpsy_reg;
    assign setup.cpcy      = cpcy_reg;
    assign setup.focal_mag = focal_mag_reg;
    assign setup.focal_neg = focal_neg_reg;
    assign setup.usable    = usable_reg;

endmodule

[sv/ppp_xform.sv]
module ppp_xform
    import ppp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  point_t point,
    input  setup_t setup,
    output logic   out_valid,
    output xf_t    xf
);

    localparam logic signed [RotW-1:0] DepthMinS = RotW'(DepthMin);

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [DiffW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [ProdW-1:0] p_xyc_reg, p_zys_reg, p_xss_reg, p_ypc_reg;
    logic signed [ProdW-1:0] p_zsc_reg, p_xcs_reg, p_yps_reg, p_zcc_reg;
    logic signed [RotW-1:0]  rx_reg, ry_reg, rz_reg;
    logic                    ok3_reg;
    xf_t                     xf_reg;

    logic signed [ProdW+1:0] sum_x, sum_y, sum_z;
    logic signed [RotW-1:0]  rx, ry, rz;

    assign sum_x = (ProdW + 2)'(p_xyc_reg) - (ProdW + 2)'(p_zys_reg);
    assign sum_y = (ProdW + 2)'(p_xss_reg) + (ProdW + 2)'(p_ypc_reg)
                   + (ProdW + 2)'(p_zsc_reg);
    assign sum_z = (ProdW + 2)'(p_yps_reg) + (ProdW + 2)'(p_zcc_reg)
                   - (ProdW + 2)'(p_xcs_reg);
    assign rx = sum_x[ProdW+1:TrigFrac];
    assign ry = sum_y[ProdW+1:TrigFrac];
    assign rz = sum_z[ProdW+1:TrigFrac];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= DiffW'($signed(point.world_x)) - DiffW'($signed(setup.cam_x));
        dy_reg <= DiffW'($signed(point.world_y)) - DiffW'($signed(setup.cam_y));
        dz_reg <= DiffW'($signed(point.world_z)) - DiffW'($signed(setup.cam_z));

        p_xyc_reg <= dx_reg * $signed(setup.ycos);
        p_zys_reg <= dz_reg * $signed(setup.ysin);
        p_xss_reg <= dx_reg * $signed(setup.spsy);
        p_ypc_reg <= dy_reg * $signed(setup.pcos);
        p_zsc_reg <= dz_reg * $signed(setup.spcy);
        p_xcs_reg <= dx_reg * $signed(setup.cpsy);
        p_yps_reg <= dy_reg * $signed(setup.psin);
        p_zcc_reg <= dz_reg * $signed(setup.cpcy);

        rx_reg  <= rx;
        ry_reg  <= ry;
        rz_reg  <= rz;
        ok3_reg <= setup.usable && (rz >= DepthMinS);

        xf_reg.ok    <= ok3_reg;
        xf_reg.neg_x <= rx_reg[RotW-1];
        xf_reg.neg_y <= ry_reg[RotW-1];
        xf_reg.mag_x <= rx_reg[RotW-1] ? RotW'(-rx_reg) : RotW'(rx_reg);
        xf_reg.mag_y <= ry_reg[RotW-1] ? RotW'(-ry_reg) : RotW'(ry_reg);
        xf_reg.den   <= rz_reg[DenW-1:0];
        xf_reg.depth <= (|rz_reg[RotW-1:DepthW]) ? {DepthW{1'b1}} : rz_reg[DepthW-1:0];
    end

    assign out_valid = v4_reg;
    assign xf        = xf_reg;

endmodule

[sv/ppp_div_pipe.sv]
module ppp_div_pipe
    import ppp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NumW-1:0] num_x,
    input  logic [NumW-1:0] num_y,
    input  logic [DenW-1:0] den,
    input  div_tag_t        tag_in,
    output logic            out_valid,
    output logic [NumW-1:0] quo_x,
    output logic [NumW-1:0] quo_y,
    output div_tag_t        tag_out
);

    logic [NumW-1:0] v_reg;
    logic [DenW-1:0] rem_x_reg [NumW];
    logic [DenW-1:0] rem_y_reg [NumW];
    logic [NumW-1:0] nq_x_reg  [NumW];
    logic [NumW-1:0] nq_y_reg  [NumW];
    logic [DenW-1:0] den_reg   [NumW];
    div_tag_t        tag_reg   [NumW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NumW-2:0], in_valid};
    end

    for (genvar g = 0; g < NumW; g++)
    begin : g_stage
        logic [DenW-1:0] rx_in, ry_in, d_in;
        logic [NumW-1:0] qx_in, qy_in;
        div_tag_t        t_in;
        logic [DenW:0]   tx, ty;
        logic            gx, gy;

        if (g == 0)
        begin : g_first
            assign rx_in = '0;
            assign ry_in = '0;
            assign qx_in = num_x;
            assign qy_in = num_y;
            assign d_in  = den;
            assign t_in  = tag_in;
        end
        else
        begin : g_next
            assign rx_in = rem_x_reg[g-1];
            assign ry_in = rem_y_reg[g-1];
            assign qx_in = nq_x_reg[g-1];
            assign qy_in = nq_y_reg[g-1];
            assign d_in  = den_reg[g-1];
            assign t_in  = tag_reg[g-1];
        end

        assign tx = {rx_in, qx_in[NumW-1]};
        assign ty = {ry_in, qy_in[NumW-1]};
        assign gx = tx >= {1'b0, d_in};
        assign gy = ty >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            rem_x_reg[g] <= gx ? DenW'(tx - {1'b0, d_in}) : tx[DenW-1:0];
            rem_y_reg[g] <= gy ? DenW'(ty - {1'b0, d_in}) : ty[DenW-1:0];
            nq_x_reg[g]  <= {qx_in[NumW-2:0], gx};
            nq_y_reg[g]  <= {qy_in[NumW-2:0], gy};
            den_reg[g]   <= d_in;
            tag_reg[g]   <= t_in;
        end
    end

    assign out_valid = v_reg[NumW-1];
    assign quo_x     = nq_x_reg[NumW-1];
    assign quo_y     = nq_y_reg[NumW-1];
    assign tag_out   = tag_reg[NumW-1];

endmodule

[sv/ppp_screen.sv]
module ppp_screen
    import ppp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [NumW-1:0] quo_x,
    input  logic [NumW-1:0] quo_y,
    input  div_tag_t        tag,
    input  setup_t          setup,
    output logic            done,
    output result_t         result
);

    localparam int HalfW   = 27;
    localparam int PartW   = HalfW + FocalW;
    localparam int FullW   = PartW + HalfW;
    localparam int LimBit  = 53;
    localparam int TW      = LimBit + 1 - 12;
    localparam int BaseW   = TW + 2;
    localparam int ScrW    = BaseW + SizeW + 1;
    localparam int ShiftS  = 25 - CoordFrac;
    localparam logic signed [BaseW-1:0] One24    = BaseW'(2 ** 24);
    localparam logic [LimBit:0]         TLimit   = (LimBit + 1)'(1) << LimBit;
    localparam logic [CoordW-1:0]       ScrMax   = 32'h7FFF_FFFF;
    localparam logic [CoordW-1:0]       ScrMin   = 32'h8000_0000;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    div_tag_t t1_reg, t2_reg, t3_reg;

    logic [PartW-1:0] ph_x_reg, pl_x_reg, ph_y_reg, pl_y_reg;
    logic             sat_x_reg, sat_y_reg, neg_x_reg, neg_y_reg;
    logic signed [BaseW-1:0] base_x_reg, base_y_reg;
    logic signed [ScrW-1:0]  m_x_reg, m_y_reg;
    result_t                 res_reg;

    logic             big_x, big_y;
    logic [FullW-1:0] p_x, p_y;
    logic [LimBit:0]  t_x, t_y;
    logic signed [BaseW-1:0] a_x, a_y;
    logic [ScrW-ShiftS-1:0]  s_x, s_y;
    logic [CoordW-1:0]       o_x, o_y;

    assign big_x = (|quo_x[NumW-1:LimBit+1]) | (quo_x[LimBit] & (|quo_x[LimBit-1:0]));
    assign big_y = (|quo_y[NumW-1:LimBit+1]) | (quo_y[LimBit] & (|quo_y[LimBit-1:0]));

    assign p_x = {ph_x_reg, HalfW'(0)} + FullW'(pl_x_reg);
    assign p_y = {ph_y_reg, HalfW'(0)} + FullW'(pl_y_reg);

    always_comb
    begin
        if (sat_x_reg || (|p_x[FullW-1:LimBit+1]) || (p_x[LimBit] && (|p_x[LimBit-1:0])))
            t_x = TLimit;
        else
            t_x = p_x[LimBit:0];
        if (sat_y_reg || (|p_y[FullW-1:LimBit+1]) || (p_y[LimBit] && (|p_y[LimBit-1:0])))
            t_y = TLimit;
        else
            t_y = p_y[LimBit:0];
    end

    assign a_x = BaseW'(t_x[LimBit:12]);
    assign a_y = BaseW'(t_y[LimBit:12]);

    assign s_x = m_x_reg[ScrW-1:ShiftS];
    assign s_y = m_y_reg[ScrW-1:ShiftS];

    always_comb
    begin
        if ((&s_x[ScrW-ShiftS-1:CoordW-1]) || !(|s_x[ScrW-ShiftS-1:CoordW-1]))
            o_x = s_x[CoordW-1:0];
        else
            o_x = s_x[ScrW-ShiftS-1] ? ScrMin : ScrMax;
        if ((&s_y[ScrW-ShiftS-1:CoordW-1]) || !(|s_y[ScrW-ShiftS-1:CoordW-1]))
            o_y = s_y[CoordW-1:0];
        else
            o_y = s_y[ScrW-ShiftS-1] ? ScrMin : ScrMax;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_x_reg  <= quo_x[LimBit:HalfW] * setup.focal_mag;
        pl_x_reg  <= quo_x[HalfW-1:0] * setup.focal_mag;
        ph_y_reg  <= quo_y[LimBit:HalfW] * setup.focal_mag;
        pl_y_reg  <= quo_y[HalfW-1:0] * setup.focal_mag;
        sat_x_reg <= big_x && (setup.focal_mag != '0);
        sat_y_reg <= big_y && (setup.focal_mag != '0);
        neg_x_reg <= tag.neg_x ^ setup.focal_neg;
        neg_y_reg <= tag.neg_y ^ setup.focal_neg;
        t1_reg    <= tag;

        base_x_reg <= neg_x_reg ? One24 - a_x : One24 + a_x;
        base_y_reg <= neg_y_reg ? One24 + a_y : One24 - a_y;
        t2_reg     <= t1_reg;

        m_x_reg <= $signed({1'b0, setup.width}) * base_x_reg;
        m_y_reg <= $signed({1'b0, setup.height}) * base_y_reg;
        t3_reg  <= t2_reg;

        res_reg.on_screen  <= t3_reg.ok;
        res_reg.screen_x   <= t3_reg.ok ? o_x : '0;
        res_reg.screen_y   <= t3_reg.ok ? o_y : '0;
        res_reg.view_depth <= t3_reg.ok ? t3_reg.depth : '0;
    end

    assign done   = v4_reg;
    assign result = res_reg;

endmodule

[sv/perspective_point_projection.sv]
// Perspective projection of world points onto a pixel screen.
// Input: a point word (world_x/y/z, signed Q16.16) is taken at each rising
// edge with start high and busy low; one point can be taken every cycle.
// Output: one result word per point, in order, on result for exactly one
// cycle with done high. The receiver cannot stall the block.
// Pipeline: 4 transform stages, 57 stages of a radix-2 pipelined divider
// for the depth division, 4 stages of focal scaling and pixel mapping.
// Throughput: one point per cycle while busy is low, set by the fully
// pipelined datapath.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (camera x/y/z, pitch, yaw, field of view, width, height). Each write
// restarts the setup sequencer, which runs three 18-step CORDIC passes and
// a bit-serial focal gain division; busy is high until it finishes.
// Reset: registers take their reset values (camera at origin, no rotation,
// 90 degree field of view, 1920 x 1080) and the same setup runs with busy
// high before the first point is taken.
module perspective_point_projection
    import ppp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  point_t          point,
    output logic            done,
    output result_t         result,
    input  logic            cfg_write,
    input  reg_idx_t        cfg_index,
    input  logic [CfgW-1:0] cfg_data
);

    setup_t          setup;
    logic            xf_valid, dv_valid;
    xf_t             xf;
    div_tag_t        tag_in, tag_out;
    logic [NumW-1:0] quo_x, quo_y;

    ppp_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .setup     (setup)
    );

    ppp_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .point     (point),
        .setup     (setup),
        .out_valid (xf_valid),
        .xf        (xf)
    );

    assign tag_in.ok    = xf.ok;
    assign tag_in.neg_x = xf.neg_x;
    assign tag_in.neg_y = xf.neg_y;
    assign tag_in.depth = xf.depth;

    ppp_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .num_x     ({xf.mag_x, RatioShift'(0)}),
        .num_y     ({xf.mag_y, RatioShift'(0)}),
        .den       (xf.den),
        .tag_in    (tag_in),
        .out_valid (dv_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .tag_out   (tag_out)
    );

    ppp_screen u_screen (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .quo_x    (quo_x),
        .quo_y    (quo_y),
        .tag      (tag_out),
        .setup    (setup),
        .done     (done),
        .result   (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n) cfg_write |=> busy)
        else $error("setup not restarted after register write");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.on_screen |->
            result.screen_x == '0 && result.screen_y == '0 && result.view_depth == '0)
        else $error("rejected point carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.on_screen |-> result.view_depth >= DepthW'(DepthMin))
        else $error("accepted point below minimum depth");

endmodule
